// ----- src/wavhc_pkg.sv -----
// Package for the WAV header checker: header tags, word positions, status codes
// and the struct of captured header fields. No dependencies.
package wavhc_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] HEADER_BYTES  = 32'd44;
   localparam logic [31:0] CHUNK_BASE    = 32'd20;
   localparam logic [15:0] MAX_BITS      = 16'd32;
   localparam logic [31:0] PCM_FMT_SIZE  = 32'd16;
   localparam logic [15:0] FORMAT_PCM    = 16'd1;

   localparam logic [3:0] WORD_RIFF      = 4'd0;
   localparam logic [3:0] WORD_RIFF_SIZE = 4'd1;
   localparam logic [3:0] WORD_WAVE      = 4'd2;
   localparam logic [3:0] WORD_FMT       = 4'd3;
   localparam logic [3:0] WORD_FMT_SIZE  = 4'd4;
   localparam logic [3:0] WORD_FORMAT    = 4'd5;
   localparam logic [3:0] WORD_RATE      = 4'd6;
   localparam logic [3:0] WORD_BYTE_RATE = 4'd7;
   localparam logic [3:0] WORD_ALIGN     = 4'd8;
   localparam logic [3:0] WORD_DATA      = 4'd9;
   localparam logic [3:0] WORD_LAST      = 4'd10;

   typedef enum logic [2:0] {
      STATUS_OK      = 3'd0,
      STATUS_RIFF    = 3'd1,
      STATUS_WAVE    = 3'd2,
      STATUS_FMT     = 3'd3,
      STATUS_DATA    = 3'd4,
      STATUS_BITS    = 3'd5,
      STATUS_NOT_PCM = 3'd6
   } status_type;

   typedef struct packed {
      logic [3:0]  word_index;
      status_type  first_fault;
      logic [31:0] riff_size;
      logic [31:0] fmt_size;
      logic [15:0] format_tag;
      logic [15:0] channels;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] align;
      logic [15:0] bit_depth;
      logic [31:0] rate_prod;
      logic        bps_zero;
      logic [3:0]  bps_shift;
   } held_type;

endpackage

// ----- src/wavhc_channels.sv -----
// Valid/ready channel interfaces for header words in and check results out.
// Depends on nothing.
interface wavhc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] header_word;

   modport source (output valid, output header_word, input ready);
   modport sink   (input valid, input header_word, output ready);
endinterface

interface wavhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] correct_chunk_size;
   logic [31:0] correct_byte_rate;
   logic [15:0] correct_block_align;
   logic [31:0] correct_data_size;
   logic [3:0]  mismatch_flags;
   logic [15:0] channels_seen;
   logic [31:0] rate_seen;

   modport source (output valid, output status, output correct_chunk_size,
                   output correct_byte_rate, output correct_block_align,
                   output correct_data_size, output mismatch_flags,
                   output channels_seen, output rate_seen, input ready);
   modport sink   (input valid, input status, input correct_chunk_size,
                   input correct_byte_rate, input correct_block_align,
                   input correct_data_size, input mismatch_flags,
                   input channels_seen, input rate_seen, output ready);
endinterface

// ----- src/wav_header_checker_core.sv -----
// Top level of the WAV header checker: file length register, capture and result.
// Depends on wavhc_pkg, wavhc_channels, wavhc_capture and wavhc_result.
//
// Usage: send the 44-byte canonical header as eleven 32-bit words on req_chan,
// first file byte in bits 7:0. Write the file length through csr_write_enable
// and csr_write_data before the header starts. After the eleventh word one
// result appears on rsp_chan: status, recomputed chunk size, byte rate, block
// align, data size, mismatch flags and the channel and rate fields seen.
// Throughput is one word per cycle. The result is valid the cycle after the
// eleventh word transfers, held in the output register. Words one to ten are
// taken while a result waits; the eleventh word stalls only while the
// previous result is still untaken. The byte-rate product is formed when the
// byte-rate word arrives, so the last word needs only a shift, adds and compares.
// Reset clears the word position, the fault note, the captured fields, the file
// length and the result valid bit.
module wav_header_checker_core
   import wavhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   wavhc_req_if.sink   req_chan,
   wavhc_rsp_if.source rsp_chan
);

   logic [31:0] file_length_ff;
   logic        accept;
   logic        last_fire;
   held_type    held;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else if (csr_write_enable) begin
         file_length_ff <= csr_write_data;
      end
   end

   assign req_chan.ready = !(held.word_index == WORD_LAST && rsp_chan.valid
                             && !rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign last_fire      = accept && held.word_index == WORD_LAST;

   wavhc_capture u_capture (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .word   (req_chan.header_word),
      .held   (held)
   );

   wavhc_result u_result (
      .clock       (clock),
      .reset       (reset),
      .last_fire   (last_fire),
      .word        (req_chan.header_word),
      .file_length (file_length_ff),
      .held        (held),
      .rsp         (rsp_chan)
   );

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(last_fire))
      else $error("result appeared without a last-word transfer");

   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready
                           && held.word_index == WORD_LAST))
      else $error("input stalled without a pending result");

   assert property (@(posedge clock) disable iff (reset)
      last_fire |=> (held.word_index == WORD_RIFF && held.first_fault == STATUS_OK))
      else $error("sequencer did not rewind after the last word");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> rsp_chan.valid)
      else $error("untaken result dropped");

endmodule

// ----- src/wavhc_capture.sv -----
// Word sequencer and field capture registers for the WAV header checker.
// Depends on wavhc_pkg.
module wavhc_capture
   import wavhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [31:0] word,
   output held_type    held
);

   logic [3:0]  word_index_ff, word_index_in;
   status_type  first_fault_ff, first_fault_in;
   logic [31:0] riff_size_ff, fmt_size_ff, sample_rate_ff, byte_rate_ff, rate_prod_ff;
   logic [15:0] format_tag_ff, channels_ff, align_ff, bit_depth_ff;
   logic        bps_zero_ff;
   logic [3:0]  bps_shift_ff;
   logic [4:0]  depth_log2;
   logic        tag_bad;
   status_type  tag_code;

   function automatic logic [4:0] ceil_log2(input logic [15:0] bits);
      logic [15:0] m;
      logic [4:0]  k;
      m = bits - 16'd1;
      k = 5'd0;
      if (bits > 16'd1) begin
         for (int i = 0; i < 16; i++) begin
            if (m[i]) begin
               k = 5'(i + 1);
            end
         end
      end
      return k;
   endfunction

   assign depth_log2 = ceil_log2(bit_depth_ff);

   always_comb begin
      tag_bad  = 1'b0;
      tag_code = STATUS_OK;
      unique case (word_index_ff)
         WORD_RIFF: begin
            tag_bad  = (word != TAG_RIFF);
            tag_code = STATUS_RIFF;
         end
         WORD_WAVE: begin
            tag_bad  = (word != TAG_WAVE);
            tag_code = STATUS_WAVE;
         end
         WORD_FMT: begin
            tag_bad  = (word != TAG_FMT);
            tag_code = STATUS_FMT;
         end
         WORD_DATA: begin
            tag_bad  = (word != TAG_DATA);
            tag_code = STATUS_DATA;
         end
         default: begin
            tag_bad  = 1'b0;
            tag_code = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      word_index_in  = word_index_ff;
      first_fault_in = first_fault_ff;
      if (accept) begin
         if (word_index_ff == WORD_LAST) begin
            word_index_in  = WORD_RIFF;
            first_fault_in = STATUS_OK;
         end else begin
            word_index_in = word_index_ff + 4'd1;
            if (first_fault_ff == STATUS_OK && tag_bad) begin
               first_fault_in = tag_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_index_ff  <= WORD_RIFF;
         first_fault_ff <= STATUS_OK;
         riff_size_ff   <= '0;
         fmt_size_ff    <= '0;
         format_tag_ff  <= '0;
         channels_ff    <= '0;
         sample_rate_ff <= '0;
         byte_rate_ff   <= '0;
         align_ff       <= '0;
         bit_depth_ff   <= '0;
         rate_prod_ff   <= '0;
         bps_zero_ff    <= 1'b1;
         bps_shift_ff   <= '0;
      end else begin
         word_index_ff  <= word_index_in;
         first_fault_ff <= first_fault_in;
         if (accept) begin
            case (word_index_ff)
               WORD_RIFF_SIZE: riff_size_ff <= word;
               WORD_FMT_SIZE:  fmt_size_ff <= word;
               WORD_FORMAT: begin
                  format_tag_ff <= word[15:0];
                  channels_ff   <= word[31:16];
               end
               WORD_RATE: sample_rate_ff <= word;
               WORD_BYTE_RATE: begin
                  byte_rate_ff <= word;
                  rate_prod_ff <= sample_rate_ff * {16'd0, channels_ff};
               end
               WORD_ALIGN: begin
                  align_ff     <= word[15:0];
                  bit_depth_ff <= word[31:16];
               end
               WORD_DATA: begin
                  bps_zero_ff  <= (depth_log2 < 5'd3);
                  bps_shift_ff <= (depth_log2 < 5'd3) ? 4'd0 : 4'(depth_log2 - 5'd3);
               end
               default: ;
            endcase
         end
      end
   end

   assign held.word_index  = word_index_ff;
   assign held.first_fault = first_fault_ff;
   assign held.riff_size   = riff_size_ff;
   assign held.fmt_size    = fmt_size_ff;
   assign held.format_tag  = format_tag_ff;
   assign held.channels    = channels_ff;
   assign held.sample_rate = sample_rate_ff;
   assign held.byte_rate   = byte_rate_ff;
   assign held.align       = align_ff;
   assign held.bit_depth   = bit_depth_ff;
   assign held.rate_prod   = rate_prod_ff;
   assign held.bps_zero    = bps_zero_ff;
   assign held.bps_shift   = bps_shift_ff;

endmodule

// ----- src/wavhc_result.sv -----
// Result computation and output register for the WAV header checker.
// Depends on wavhc_pkg and wavhc_rsp_if.
module wavhc_result
   import wavhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        last_fire,
   input  logic [31:0] word,
   input  logic [31:0] file_length,
   input  held_type    held,
   wavhc_rsp_if.source rsp
);

   logic        valid_ff;
   status_type  status_ff, status_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] align_ff, align_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [3:0]  flags_ff, flags_in;
   logic [15:0] channels_ff;
   logic [31:0] sample_rate_ff;

   always_comb begin
      if (held.first_fault != STATUS_OK) begin
         status_in = held.first_fault;
      end else if (held.bit_depth > MAX_BITS) begin
         status_in = STATUS_BITS;
      end else if (held.format_tag != FORMAT_PCM || held.fmt_size != PCM_FMT_SIZE) begin
         status_in = STATUS_NOT_PCM;
      end else begin
         status_in = STATUS_OK;
      end
      chunk_in = CHUNK_BASE + held.fmt_size + word;
      rate_in  = held.bps_zero ? 32'd0 : (held.rate_prod << held.bps_shift);
      align_in = held.bps_zero ? 16'd0 : (held.channels << held.bps_shift);
      dsize_in = file_length - HEADER_BYTES;
      flags_in = {dsize_in != word, align_in != held.align,
                  rate_in != held.byte_rate, chunk_in != held.riff_size};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (last_fire) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (last_fire) begin
         status_ff      <= status_in;
         chunk_ff       <= chunk_in;
         rate_ff        <= rate_in;
         align_ff       <= align_in;
         dsize_ff       <= dsize_in;
         flags_ff       <= flags_in;
         channels_ff    <= held.channels;
         sample_rate_ff <= held.sample_rate;
      end
   end

   assign rsp.valid               = valid_ff;
   assign rsp.status              = status_ff;
   assign rsp.correct_chunk_size  = chunk_ff;
   assign rsp.correct_byte_rate   = rate_ff;
   assign rsp.correct_block_align = align_ff;
   assign rsp.correct_data_size   = dsize_ff;
   assign rsp.mismatch_flags      = flags_ff;
   assign rsp.channels_seen       = channels_ff;
   assign rsp.rate_seen           = sample_rate_ff;

endmodule
